[hw/rtl/sha1sh_pkg.sv]
package sha1sh_pkg;

	// Action codes on the message channel
	localparam logic [1:0] ACT_ABSORB  = 2'd0;
	localparam logic [1:0] ACT_DIGEST  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Initial chaining value, word 0 at index 0
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [4:0][31:0] H_INIT = {H4, H3, H2, H1, H0};

	// Round constants, one per group of twenty rounds
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int unsigned ROUNDS = 80;
	localparam int unsigned BLOCK_WORDS = 16;

	// Working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} vars_t;

	// Build one big-endian block word, applying message padding on a digest
	function automatic logic [31:0] pad_word(
		input logic [3:0]  widx,
		input logic        dig,
		input logic        blk,
		input logic [31:0] mem_word,
		input logic [5:0]  pend,
		input logic [63:0] bits
	);
		logic [31:0] res;
		logic [5:0]  idx;
		logic [7:0]  mb;
		logic [7:0]  lb;
		logic        short_pad;
		res = '0;
		short_pad = (pend[5:3] != 3'b111);
		for (int l = 0; l < 4; l++) begin
			idx = {widx, 2'(l)};
			mb = mem_word[8*(3-l) +: 8];
			lb = bits[{~idx[2:0], 3'b000} +: 8];
			if (!dig) begin
				res[8*(3-l) +: 8] = mb;
			end else if (!blk) begin
				if (idx < pend)
					res[8*(3-l) +: 8] = mb;
				else if (idx == pend)
					res[8*(3-l) +: 8] = PAD_MARK;
				else if (short_pad && idx[5:3] == 3'b111)
					res[8*(3-l) +: 8] = lb;
				else
					res[8*(3-l) +: 8] = 8'h00;
			end else begin
				if (idx[5:3] == 3'b111)
					res[8*(3-l) +: 8] = lb;
				else
					res[8*(3-l) +: 8] = 8'h00;
			end
		end
		return res;
	endfunction

endpackage

[hw/rtl/sha1sh_msg_if.sv]
interface sha1sh_msg_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] msg_byte;

	modport source(output valid, output action, output msg_byte, input ready);
	modport sink(input valid, input action, input msg_byte, output ready);
endinterface

[hw/rtl/sha1sh_digest_if.sv]
interface sha1sh_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink(input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

[hw/rtl/sha1sh_round.sv]
module sha1sh_round
	import sha1sh_pkg::*;
(
	input  vars_t       cur,
	input  logic [31:0] w,
	input  logic [6:0]  rnd,
	output vars_t       nxt
);

	logic [31:0] f;
	logic [31:0] k;

	// Pick the boolean function and constant for this round group
	always_comb begin
		if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K0;
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K1;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K3;
		end
	end

	// One round: new a from the sum, rotate the rest down
	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

[hw/rtl/sha1sh_sched.sv]
module sha1sh_sched
	import sha1sh_pkg::*;
(
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] load_word,
	input  logic        step,
	output logic [31:0] w_cur
);

	// Sixteen-word window; entry 0 is the word for the current round
	logic [31:0] win_q [BLOCK_WORDS];
	logic [31:0] mix;

	assign mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_cur = win_q[0];

	// Shift in block words on load, expanded words on each round
	always_ff @(posedge clk) begin
		if (load || step) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[BLOCK_WORDS-1] <= load ? load_word : {mix[30:0], mix[31]};
		end
	end

endmodule

[hw/rtl/sha1_stream_hasher.sv]
// SHA-1 over a byte stream. Each absorb beat on msg writes the byte into a 16-word block
// buffer memory; the beat that completes a 64-byte block starts a compression during which
// msg is not ready: the block streams out of the buffer memory (one word per cycle) into the
// schedule window, then runs on the single round unit (one round per cycle) and folds into
// the chaining value. A digest beat runs the same compression on a padded copy, once or twice
// (twice when more than 55 bytes are pending), then presents the five digest words on the
// digest channel, word 0 first, leaving the stored state untouched. Action code 3 is taken
// and ignored.
module sha1_stream_hasher
	import sha1sh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	sha1sh_msg_if.sink       msg,
	sha1sh_digest_if.source  digest
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [63:0]      count_q;
	logic [4:0][31:0] chain_q;
	logic [4:0][31:0] hv_q;
	vars_t            vars_q;
	vars_t            vars_nxt;
	logic             dig_q;
	logic             blk_q;
	logic [4:0]       ld_q;
	logic [6:0]       rnd_q;
	logic [2:0]       widx_q;

	logic [31:0]      mem_q [BLOCK_WORDS];
	logic [31:0]      rd_q;
	logic [31:0]      blk_word;
	logic [31:0]      w_cur;
	logic [4:0]       lane_sh;
	logic [4:0][31:0] sum;
	logic             msg_acc;
	logic             out_acc;
	logic             sched_load;
	logic             sched_step;

	assign msg.ready = (state_q == ST_IDLE);
	assign msg_acc   = msg.valid && msg.ready;
	assign out_acc   = digest.valid && digest.ready;

	// Write bytes big-endian into the word-wide buffer
	assign lane_sh = {~count_q[1:0], 3'b000};
	always_ff @(posedge clk) begin
		if (msg_acc && msg.action == ACT_ABSORB)
			mem_q[count_q[5:2]][lane_sh +: 8] <= msg.msg_byte;
	end

	// Registered read, addressed by the load counter
	always_ff @(posedge clk) begin
		rd_q <= mem_q[ld_q[3:0]];
	end

	// Pad the word read in the previous cycle
	assign blk_word = pad_word(ld_q[3:0] - 4'd1, dig_q, blk_q, rd_q, count_q[5:0],
		{count_q[60:0], 3'b000});

	assign sched_load = (state_q == ST_LOAD) && (ld_q != 5'd0);
	assign sched_step = (state_q == ST_ROUND);

	sha1sh_sched u_sched (
		.clk       (clk),
		.load      (sched_load),
		.load_word (blk_word),
		.step      (sched_step),
		.w_cur     (w_cur)
	);

	sha1sh_round u_round (
		.cur (vars_q),
		.w   (w_cur),
		.rnd (rnd_q),
		.nxt (vars_nxt)
	);

	// Feed-forward sum of the block result
	assign sum[0] = hv_q[0] + vars_q.a;
	assign sum[1] = hv_q[1] + vars_q.b;
	assign sum[2] = hv_q[2] + vars_q.c;
	assign sum[3] = hv_q[3] + vars_q.d;
	assign sum[4] = hv_q[4] + vars_q.e;

	// Working registers of the compression
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && ld_q == 5'(BLOCK_WORDS))
			vars_q <= vars_t'({hv_q[0], hv_q[1], hv_q[2], hv_q[3], hv_q[4]});
		else if (state_q == ST_ROUND)
			vars_q <= vars_nxt;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			chain_q <= H_INIT;
			hv_q    <= H_INIT;
			dig_q   <= 1'b0;
			blk_q   <= 1'b0;
			ld_q    <= '0;
			rnd_q   <= '0;
			widx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						case (msg.action)
							ACT_ABSORB: begin
								count_q <= count_q + 64'd1;
								if (count_q[5:0] == 6'h3f) begin
									hv_q    <= chain_q;
									dig_q   <= 1'b0;
									blk_q   <= 1'b0;
									ld_q    <= '0;
									state_q <= ST_LOAD;
								end
							end
							ACT_DIGEST: begin
								hv_q    <= chain_q;
								dig_q   <= 1'b1;
								blk_q   <= 1'b0;
								ld_q    <= '0;
								state_q <= ST_LOAD;
							end
							ACT_RESTART: begin
								chain_q <= H_INIT;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOAD: begin
					// Stream the block in, then start the rounds
					if (ld_q == 5'(BLOCK_WORDS)) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						ld_q <= ld_q + 5'd1;
					end
				end
				ST_ROUND: begin
					if (rnd_q == 7'(ROUNDS - 1))
						state_q <= ST_FOLD;
					else
						rnd_q <= rnd_q + 7'd1;
				end
				ST_FOLD: begin
					hv_q <= sum;
					if (!dig_q) begin
						chain_q <= sum;
						state_q <= ST_IDLE;
					end else if (!blk_q && count_q[5:3] == 3'b111) begin
						blk_q   <= 1'b1;
						ld_q    <= '0;
						state_q <= ST_LOAD;
					end else begin
						widx_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Advance through the five words on each taken beat
					if (out_acc) begin
						if (widx_q == 3'd4)
							state_q <= ST_IDLE;
						else
							widx_q <= widx_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digest channel
	assign digest.valid       = (state_q == ST_EMIT);
	assign digest.word_index  = widx_q;
	assign digest.last_word   = (widx_q == 3'd4);
	always_comb begin
		case (widx_q)
			3'd0:    digest.digest_word = hv_q[0];
			3'd1:    digest.digest_word = hv_q[1];
			3'd2:    digest.digest_word = hv_q[2];
			3'd3:    digest.digest_word = hv_q[3];
			default: digest.digest_word = hv_q[4];
		endcase
	end

endmodule

[hw/rtl/sha1sh_checker.sv]
module sha1sh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_ready,
	input logic        digest_valid,
	input logic        digest_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// Hold a stalled digest beat
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=>
		digest_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest beat changed while stalled");

	// Advance words back to back until the last one
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !last_word |=>
		digest_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest words not in sequence");

	// Drop message input while a digest is shown
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> !msg_ready)
		else $error("message ready during digest output");

	// Flag the last word only at index four
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (last_word == (word_index == 3'd4)))
		else $error("last word flag out of place");

	// Return to accepting input after the last word
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && last_word |=> msg_ready && !digest_valid)
		else $error("no return to idle after digest");

endmodule

bind sha1_stream_hasher sha1sh_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_ready    (msg.ready),
	.digest_valid (digest.valid),
	.digest_ready (digest.ready),
	.digest_word  (digest.digest_word),
	.word_index   (digest.word_index),
	.last_word    (digest.last_word)
);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import sha1sh_pkg::*;

	// Action code with no meaning; the block takes it and does nothing
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 250;

	typedef logic [0:4][31:0]  sum_t;
	typedef logic [0:15][31:0] block_t;
	typedef logic [0:63][7:0]  bytes_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} word_beat_t;

	typedef struct {
		logic [1:0] act;
		logic [7:0] mbyte;
		bit         typed;
		sum_t       sum;
	} script_row_t;

	localparam sum_t SUM_INIT  = {H0, H1, H2, H3, H4};
	localparam sum_t SUM_EMPTY = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890,
		32'hafd80709};
	localparam sum_t SUM_ABC   = {32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c,
		32'h9cd0d89d};

	logic clk;
	logic arst_n;

	sha1sh_msg_if    msg_ch();
	sha1sh_digest_if dig_ch();

	sha1_stream_hasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	// Hash state as the block should hold it
	sum_t        chain_words;
	bytes_t      block_bytes;
	logic [63:0] msg_len;

	word_beat_t  due_words[$];
	script_row_t opening_script[21];

	bit no_gaps;
	int fails;
	int beats_in;
	int digests_asked;
	int bytes_taken;
	int words_checked;
	int quiet_cycles;

	// One SHA-1 compression of a 16-word block into a chaining value
	function automatic sum_t sha1_compress(input sum_t hv, input block_t blk);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int r;
		for (r = 0; r < 16; r++)
			w[r] = blk[r];
		for (r = 16; r < 80; r++) begin
			x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
			w[r] = {x[30:0], x[31]};
		end
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3]; e = hv[4];
		for (r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		return {hv[0] + a, hv[1] + b, hv[2] + c, hv[3] + d, hv[4] + e};
	endfunction

	// Pad a copy of the pending bytes and finish the hash on a copy of the chain
	function automatic sum_t digest_of_pending();
		logic [0:127][7:0] padded;
		logic [63:0]       bits;
		sum_t              hv;
		int                pend;
		int                len_pos;
		padded = '0;
		pend = int'(msg_len[5:0]);
		bits = msg_len << 3;
		for (int i = 0; i < pend; i++)
			padded[i] = block_bytes[i];
		padded[pend] = PAD_MARK;
		len_pos = (pend < 56) ? 56 : 120;
		for (int i = 0; i < 8; i++)
			padded[len_pos + i] = bits[63 - 8*i -: 8];
		hv = sha1_compress(chain_words, padded[0:63]);
		if (pend >= 56)
			hv = sha1_compress(hv, padded[64:127]);
		return hv;
	endfunction

	// Queue the five words of one digest, most significant first
	function automatic void queue_sum(input sum_t s);
		word_beat_t wb;
		for (int i = 0; i < 5; i++) begin
			wb.word = s[i];
			wb.idx = 3'(i);
			wb.last = (i == 4);
			due_words.push_back(wb);
		end
	endfunction

	// Advance the expected state by one accepted message beat
	task automatic take_beat(input logic [1:0] act, input logic [7:0] mbyte);
		case (act)
			ACT_ABSORB: begin
				block_bytes[msg_len[5:0]] = mbyte;
				msg_len = msg_len + 64'd1;
				bytes_taken++;
				if (msg_len[5:0] == 6'd0)
					chain_words = sha1_compress(chain_words, block_bytes);
			end
			ACT_DIGEST: begin
				queue_sum(digest_of_pending());
				digests_asked++;
			end
			ACT_RESTART: begin
				chain_words = SUM_INIT;
				msg_len = '0;
			end
			default: begin
				// unused code leaves everything as it is
			end
		endcase
	endtask

	// Drive one message beat, with random gaps, and hold until it is taken
	task automatic send_beat(input logic [1:0] act, input logic [7:0] mbyte);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 8) begin
			msg_ch.valid <= 1'b0;
			@(negedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.action <= act;
		msg_ch.msg_byte <= mbyte;
		do @(posedge clk); while (!msg_ch.ready);
		beats_in++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		msg_ch.valid <= 1'b0;
	endtask

	task automatic send_and_predict(input logic [1:0] act, input logic [7:0] mbyte);
		send_beat(act, mbyte);
		take_beat(act, mbyte);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the digest side at random, except in the calm stretch
	initial begin
		dig_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			dig_ch.ready <= no_gaps || ($urandom_range(99) >= 8);
		end
	end

	// Compare each digest word with the oldest one due
	always @(posedge clk) begin
		word_beat_t want;
		if (arst_n && dig_ch.valid && dig_ch.ready) begin
			if (due_words.size() == 0) begin
				$error("digest_word %h arrived with nothing due", dig_ch.digest_word);
				fails++;
			end else begin
				want = due_words.pop_front();
				words_checked++;
				if (dig_ch.digest_word !== want.word) begin
					$error("digest_word: expected %h, got %h", want.word, dig_ch.digest_word);
					fails++;
				end
				if (dig_ch.word_index !== want.idx) begin
					$error("word_index: expected %0d, got %0d", want.idx, dig_ch.word_index);
					fails++;
				end
				if (dig_ch.last_word !== want.last) begin
					$error("last_word: expected %0d, got %0d", want.last, dig_ch.last_word);
					fails++;
				end
			end
		end
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d words still due", quiet_cycles,
				due_words.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int pend;
		logic [1:0] act;
		msg_ch.valid = 1'b0;
		msg_ch.action = ACT_ABSORB;
		msg_ch.msg_byte = 8'h00;
		arst_n = 1'b0;
		no_gaps = 1'b0;
		fails = 0;
		beats_in = 0;
		digests_asked = 0;
		bytes_taken = 0;
		words_checked = 0;
		quiet_cycles = 0;
		chain_words = SUM_INIT;
		block_bytes = '0;
		msg_len = '0;

		// Known digests are typed in; the rest go through the predictor
		opening_script = '{
			'{ACT_DIGEST,  8'h00, 1'b1, SUM_EMPTY},
			'{ACT_ABSORB,  8'h61, 1'b0, '0},
			'{ACT_ABSORB,  8'h62, 1'b0, '0},
			'{ACT_ABSORB,  8'h63, 1'b0, '0},
			'{ACT_DIGEST,  8'hff, 1'b1, SUM_ABC},
			'{ACT_UNUSED,  8'hff, 1'b0, '0},
			'{ACT_DIGEST,  8'h00, 1'b1, SUM_ABC},
			'{ACT_RESTART, 8'h5a, 1'b0, '0},
			'{ACT_DIGEST,  8'h00, 1'b1, SUM_EMPTY},
			'{ACT_ABSORB,  8'h00, 1'b0, '0},
			'{ACT_ABSORB,  8'hff, 1'b0, '0},
			'{ACT_DIGEST,  8'h00, 1'b0, '0},
			'{ACT_UNUSED,  8'h00, 1'b0, '0},
			'{ACT_ABSORB,  8'h80, 1'b0, '0},
			'{ACT_DIGEST,  8'h00, 1'b0, '0},
			'{ACT_RESTART, 8'hff, 1'b0, '0},
			'{ACT_ABSORB,  8'h61, 1'b0, '0},
			'{ACT_ABSORB,  8'h62, 1'b0, '0},
			'{ACT_ABSORB,  8'h63, 1'b0, '0},
			'{ACT_DIGEST,  8'h00, 1'b1, SUM_ABC},
			'{ACT_RESTART, 8'h00, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the opening script
		foreach (opening_script[i]) begin
			send_beat(opening_script[i].act, opening_script[i].mbyte);
			if (opening_script[i].typed) begin
				queue_sum(opening_script[i].sum);
				digests_asked++;
			end else begin
				take_beat(opening_script[i].act, opening_script[i].mbyte);
			end
		end

		// One long message across a block boundary, digests at the padding edges
		send_and_predict(ACT_RESTART, 8'($urandom));
		for (int n = 0; n < 66; n++) begin
			no_gaps = (n < 48);
			pend = n % 64;
			if (pend == 55 || pend == 56 || pend == 63 || (n > 0 && pend == 0) ||
					$urandom_range(9) == 0)
				send_and_predict(ACT_DIGEST, 8'($urandom));
			if ($urandom_range(19) == 0)
				send_and_predict(ACT_UNUSED, 8'($urandom));
			send_and_predict(ACT_ABSORB, 8'($urandom));
		end
		send_and_predict(ACT_DIGEST, 8'($urandom));
		no_gaps = 1'b0;

		// Hold the sender until every digest word is back
		drop_valid();
		while (due_words.size() != 0)
			@(negedge clk);

		// Short messages with the occasional stray action
		repeat (3) begin
			send_and_predict(ACT_RESTART, 8'($urandom));
			repeat ($urandom_range(8)) begin
				act = ($urandom_range(9) == 0) ? 2'($urandom) : ACT_ABSORB;
				send_and_predict(act, 8'($urandom));
			end
			send_and_predict(ACT_DIGEST, 8'($urandom));
		end

		// Drain and leave room for anything stray
		drop_valid();
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d message beats: %0d bytes absorbed, %0d digests, %0d words checked",
			beats_in, bytes_taken, digests_asked, words_checked);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1sh_msg_if.sv
hw/rtl/sha1sh_digest_if.sv
hw/rtl/sha1sh_round.sv
hw/rtl/sha1sh_sched.sv
hw/rtl/sha1_stream_hasher.sv
hw/rtl/sha1sh_checker.sv
tb/testbench.sv
